// ===== design/lirs_pkg.sv =====
// Shared types and constants for the least-in-flight read scheduler.
// Holds the heap entry layout, request/status codes and default sizes.
// No dependencies.
package lirs_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int ARITY_DEF    = 16;
  localparam int NUM_READERS  = 4096;
  localparam int ID_W         = 12;
  localparam int KEY_W        = 8;
  localparam int LEFT_W       = 12;

  localparam logic [KEY_W-1:0] KEY_NONE  = 8'hFF;
  localparam logic [KEY_W-1:0] MAX_RESET = 8'd4;

  localparam logic [1:0] ACT_INSERT   = 2'd0;
  localparam logic [1:0] ACT_ISSUE    = 2'd1;
  localparam logic [1:0] ACT_COMPLETE = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ID_W-1:0]   reader;
    logic [LEFT_W-1:0] left;
  } hentry_t;

endpackage

// ===== design/least_inflight_read_scheduler.sv =====
// Least-in-flight read scheduler: top level with sequencer and two RAMs.
// Depends on lirs_pkg and lirs_ram.
//
// Usage:
// - Input channel (in_valid/in_stall) carries one request: action, reader_id,
//   block_count. Output channel (out_valid/out_stall) returns one result per
//   request: status, granted_reader, reader_finished.
// - One request is worked at a time; in_stall is low only while idle.
// - Each request runs as a sequence of sequencer steps. Insert climbs the new
//   entry toward the roots until it reaches the root level or a parent
//   compare stops it. Completion ends at once for an absent reader or at
//   count zero, else lowers the count and climbs. Issue scans the roots
//   (min(roots, entries) of them) for the least count and, unless the reader
//   finished, sifts it down, scanning the children of each level. A finished
//   reader replaced by the last entry climbs before its sift. The single
//   read port of the heap RAM reads one entry per cycle.
// - Result leaves through an output register; if the receiver stalls, the
//   result holds there and the next result waits before it is loaded.
// - Reset (rst, synchronous) clears the count and then runs a clearing pass
//   over the reader map; in_stall stays high during it.
//   The limit register (cfg_wr_en/cfg_wr_data) resets to 4; write it only
//   while no request is in flight.
module least_inflight_read_scheduler #(
  parameter int CAPACITY = lirs_pkg::CAPACITY_DEF,
  parameter int ARITY    = lirs_pkg::ARITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [lirs_pkg::KEY_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  action,
  input  logic [lirs_pkg::ID_W-1:0]   reader_id,
  input  logic [lirs_pkg::LEFT_W-1:0] block_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [lirs_pkg::ID_W-1:0]   granted_reader,
  output logic                        reader_finished
);
  import lirs_pkg::*;

  localparam int IW  = $clog2(CAPACITY);          // heap slot index
  localparam int CW  = $clog2(CAPACITY + 1);      // entry count
  localparam int PW  = CW + $clog2(ARITY) + 1;    // child index range
  localparam int SW  = IW + 1;                    // map entry: present + slot
  localparam int RW  = $clog2(NUM_READERS);
  localparam int HW  = $bits(hentry_t);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_INS_CHK, S_CMP_CHK, S_CMP_KEY, S_SU_CHK, S_SU_CMP,
    S_SD_START, S_SCAN, S_ROOT_DEC, S_DN_DEC, S_RM_WAIT, S_RE_RD, S_RE_WAIT,
    S_RESP
  } state_t;

  state_t            state;
  logic [RW-1:0]     clr;
  logic [CW-1:0]     active;
  logic [KEY_W-1:0]  max_inflight;
  hentry_t           cur;          // entry riding the hole during a sift
  logic [IW-1:0]     pos;          // hole position
  logic [IW-1:0]     rm_idx;       // slot vacated by a finished reader
  logic              su_remove;    // sift up is part of a removal
  logic              scan_root;    // scan picks a root rather than a child
  logic [PW-1:0]     r;
  logic [PW-1:0]     scan_end;
  logic              pend;
  logic [IW-1:0]     pend_idx;
  logic [KEY_W-1:0]  best_key;
  logic [IW-1:0]     best_idx;
  hentry_t           best_ent;
  logic [ID_W-1:0]   req_rid;
  logic [LEFT_W-1:0] req_blocks;
  logic [1:0]        res_status;
  logic [ID_W-1:0]   res_grant;
  logic              res_fin;

  // memory ports
  logic          heap_we;
  logic [IW-1:0] heap_waddr;
  hentry_t       heap_wdata;
  logic [IW-1:0] heap_raddr;
  logic [HW-1:0] heap_rraw;
  hentry_t       heap_rdata;
  logic          slot_we;
  logic [RW-1:0] slot_waddr;
  logic [SW-1:0] slot_wdata;
  logic [SW-1:0] slot_rdata;

  logic [IW-1:0] parent;
  logic          su_cond;
  logic [PW-1:0] first;
  logic [PW-1:0] sd_end;
  logic [CW-1:0] last;

  assign heap_rdata = hentry_t'(heap_rraw);
  assign parent  = IW'((32'(pos) / ARITY) - 1);
  assign su_cond = (32'(pos) >= ARITY) && (CW'(pos) < active);
  assign first   = PW'((32'(pos) + 1) * ARITY);
  assign sd_end  = (PW'(first + PW'(ARITY)) > PW'(active)) ? PW'(active)
                                                          : PW'(first + PW'(ARITY));
  assign last    = active - CW'(1);
  assign in_stall = (state != S_IDLE);

  lirs_ram #(.DEPTH(CAPACITY), .WIDTH(HW)) u_heap (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rraw)
  );

  lirs_ram #(.DEPTH(NUM_READERS), .WIDTH(SW)) u_slot (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (reader_id),
    .rdata (slot_rdata)
  );

  // Memory port control per sequencer step
  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = pos;
    heap_wdata = cur;
    heap_raddr = r[IW-1:0];
    slot_we    = 1'b0;
    slot_waddr = cur.reader;
    slot_wdata = {1'b1, pos};
    case (state)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr;
        slot_wdata = '0;
      end
      S_CMP_CHK: heap_raddr = slot_rdata[IW-1:0];
      S_SU_CHK: begin
        heap_raddr = parent;
        if (!su_cond) begin
          // drop the riding entry into the hole
          heap_we = 1'b1;
          slot_we = 1'b1;
        end
      end
      S_SU_CMP: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
        if (cur.key < heap_rdata.key) begin
          // move the parent down into the hole
          heap_wdata = heap_rdata;
          slot_waddr = heap_rdata.reader;
        end
      end
      S_SD_START: begin
        if (first >= PW'(active)) begin
          heap_we = 1'b1;
          slot_we = 1'b1;
        end
      end
      S_DN_DEC: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
        if (best_idx != pos) begin
          // lift the least child into the hole
          heap_wdata = best_ent;
          slot_waddr = best_ent.reader;
        end
      end
      S_ROOT_DEC: begin
        heap_raddr = last[IW-1:0];
        if (best_key < max_inflight && best_ent.left <= LEFT_W'(1)) begin
          // mark the finished reader absent
          slot_we    = 1'b1;
          slot_waddr = best_ent.reader;
          slot_wdata = '0;
        end
      end
      S_RE_RD: heap_raddr = rm_idx;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr          <= '0;
      active       <= '0;
      max_inflight <= MAX_RESET;
      out_valid    <= 1'b0;
      pend         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_inflight <= cfg_wr_data;
      end
      // S_RESP reloads the output register itself
      if (out_valid && !out_stall && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + RW'(1);
          if (clr == RW'(NUM_READERS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_rid    <= reader_id;
            req_blocks <= block_count;
            res_grant  <= '0;
            res_fin    <= 1'b0;
            case (action)
              ACT_INSERT: begin
                if (32'(active) >= CAPACITY) begin
                  res_status <= ST_FULL;
                  state      <= S_RESP;
                end else begin
                  res_status <= ST_DONE;
                  state      <= S_INS_CHK;
                end
              end
              ACT_ISSUE: begin
                res_status <= ST_DONE;
                r          <= '0;
                scan_end   <= (32'(active) < ARITY) ? PW'(active) : PW'(ARITY);
                pend       <= 1'b0;
                best_key   <= KEY_NONE;
                best_idx   <= '0;
                scan_root  <= 1'b1;
                state      <= S_SCAN;
              end
              ACT_COMPLETE: begin
                res_status <= ST_DONE;
                state      <= S_CMP_CHK;
              end
              default: begin
                res_status <= ST_DONE;
                state      <= S_RESP;
              end
            endcase
          end
        end
        S_INS_CHK: begin
          if (!slot_rdata[IW] && req_blocks != '0) begin
            cur       <= '{key: '0, reader: req_rid, left: req_blocks};
            pos       <= active[IW-1:0];
            active    <= active + CW'(1);
            su_remove <= 1'b0;
            state     <= S_SU_CHK;
          end else begin
            state <= S_RESP;
          end
        end
        S_CMP_CHK: begin
          if (!slot_rdata[IW] || CW'(slot_rdata[IW-1:0]) >= active) begin
            res_status <= ST_ABSENT;
            state      <= S_RESP;
          end else begin
            pos   <= slot_rdata[IW-1:0];
            state <= S_CMP_KEY;
          end
        end
        S_CMP_KEY: begin
          if (heap_rdata.key != '0) begin
            cur       <= '{key: heap_rdata.key - KEY_W'(1), reader: heap_rdata.reader,
                           left: heap_rdata.left};
            su_remove <= 1'b0;
            state     <= S_SU_CHK;
          end else begin
            state <= S_RESP;
          end
        end
        S_SU_CHK: begin
          if (su_cond) begin
            state <= S_SU_CMP;
          end else begin
            state <= su_remove ? S_RE_RD : S_RESP;
          end
        end
        S_SU_CMP: begin
          if (cur.key < heap_rdata.key) begin
            pos   <= parent;
            state <= S_SU_CHK;
          end else begin
            state <= su_remove ? S_RE_RD : S_RESP;
          end
        end
        S_RE_RD:   state <= S_RE_WAIT;
        S_RE_WAIT: begin
          // sift down whatever now sits in the vacated slot
          cur   <= heap_rdata;
          pos   <= rm_idx;
          state <= S_SD_START;
        end
        S_SD_START: begin
          if (first >= PW'(active)) begin
            state <= S_RESP;
          end else begin
            r         <= first;
            scan_end  <= sd_end;
            pend      <= 1'b0;
            best_key  <= cur.key;
            best_idx  <= pos;
            best_ent  <= cur;
            scan_root <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          // compare the entry read last cycle; ties keep the lower slot
          if (pend && heap_rdata.key < best_key) begin
            best_key <= heap_rdata.key;
            best_idx <= pend_idx;
            best_ent <= heap_rdata;
          end
          if (r < scan_end) begin
            pend     <= 1'b1;
            pend_idx <= r[IW-1:0];
            r        <= r + PW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= scan_root ? S_ROOT_DEC : S_DN_DEC;
            end
          end
        end
        S_ROOT_DEC: begin
          if (best_key >= max_inflight) begin
            res_status <= ST_NONE;
            state      <= S_RESP;
          end else begin
            res_grant <= best_ent.reader;
            if (best_ent.left <= LEFT_W'(1)) begin
              res_fin <= 1'b1;
              active  <= last;
              rm_idx  <= best_idx;
              state   <= (CW'(best_idx) != last) ? S_RM_WAIT : S_RESP;
            end else begin
              cur   <= '{key: best_key + KEY_W'(1), reader: best_ent.reader,
                         left: best_ent.left - LEFT_W'(1)};
              pos   <= best_idx;
              state <= S_SD_START;
            end
          end
        end
        S_RM_WAIT: begin
          // last entry fills the vacated slot, sift it up first
          cur       <= heap_rdata;
          pos       <= rm_idx;
          su_remove <= 1'b1;
          state     <= S_SU_CHK;
        end
        S_DN_DEC: begin
          if (best_idx == pos) begin
            state <= S_RESP;
          end else begin
            pos   <= best_idx;
            state <= S_SD_START;
          end
        end
        S_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            status          <= res_status;
            granted_reader  <= res_grant;
            reader_finished <= res_fin;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/lirs_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered. No dependencies.
module lirs_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
